// File: src/coo2csr_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the coordinate to compressed-row converter.
// No dependencies; imported by the top level.
package coo2csr_pkg;

   // Fixed field widths of the command and response transfers
   localparam int DIM_W    = 11;
   localparam int CNT_W    = 13;
   localparam int VAL_W    = 64;
   localparam int COL_W    = 10;
   localparam int CSR_W    = 13;
   localparam int CSR_IDX_W = 2;

   // Register indexes on the CSR port
   localparam logic [CSR_IDX_W-1:0] REG_NUM_ROWS       = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_NUM_COLS       = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DECLARED_COUNT = 2'd2;

   typedef enum logic [1:0] {
      MODE_LOAD      = 2'd0,
      MODE_BUILD     = 2'd1,
      MODE_READ_PTR  = 2'd2,
      MODE_READ_SLOT = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_BOUNDS  = 3'd1,
      ST_COUNT   = 3'd2,
      ST_FULL    = 3'd3,
      ST_BADREAD = 3'd4
   } status_type;

   typedef struct packed {
      mode_type               mode;
      logic [DIM_W-1:0]       row_number;
      logic [DIM_W-1:0]       col_number;
      logic [VAL_W-1:0]       value_bits;
      logic [CNT_W-1:0]       read_position;
   } req_type;

   typedef struct packed {
      status_type             status;
      logic [CNT_W-1:0]       stored_count;
      logic [CNT_W-1:0]       row_start;
      logic [COL_W-1:0]       col_out;
      logic [VAL_W-1:0]       value_out;
   } rsp_type;

endpackage

// File: src/coo2csr_ram.sv
`timescale 1ns / 1ps
// Simple dual-port synchronous RAM: one write port, one read port,
// registered read data (read-first on a same-address collision). No dependencies.
module coo2csr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: src/coo_to_csr_converter_top.sv
`timescale 1ns / 1ps
// Coordinate to compressed-row converter: entry store, build sequencer,
// pointer and slot memories. Depends on coo2csr_pkg and coo2csr_ram.
// Load and read commands: one per cycle while not busy, result on the cycle after the transfer.
// Build: bounds scan, pointer clear, count, prefix and scatter passes over the
// RAMs while busy, then the result; a count mismatch is reported at once and a
// bounds failure in the scan ends the build early.
// Reset (synchronous) clears control state only; no clearing pass is needed.
// The result strobe lasts one cycle and cannot be held off by the receiver.
module coo_to_csr_converter_top
   import coo2csr_pkg::*;
#(
   parameter int MAX_ROWS    = 1024,
   parameter int MAX_COLS    = 1024,
   parameter int MAX_ENTRIES = 4096
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  req_type              req_data,
   output logic                 rsp_valid,
   output rsp_type              rsp_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   localparam int RIDX_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int PIDX_W = $clog2(MAX_ROWS + 1);
   localparam int CIDX_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int CCNT_W = $clog2(MAX_COLS + 1);
   localparam int EIDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int ECNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int IW     = $clog2(MAX_ROWS + MAX_ENTRIES + 2);
   localparam int CRD_W  = RIDX_W + CIDX_W + VAL_W;
   localparam int PK_W   = CIDX_W + VAL_W;

   typedef enum logic [2:0] {
      S_IDLE, S_SCAN, S_CLEAR, S_COUNT, S_PREFIX, S_SCATTER
   } state_type;

   typedef enum logic [1:0] {
      RK_NONE, RK_PTR, RK_SLOT
   } rsp_kind_type;

   // Control and configuration registers
   state_type            state_ff;
   logic [IW-1:0]        idx_ff;
   logic [PIDX_W-1:0]    rows_ff;
   logic [CCNT_W-1:0]    cols_ff;
   logic [CNT_W-1:0]     decl_ff;
   logic [ECNT_W-1:0]    total_ff;
   logic                 built_ff;

   // Read-modify-write pipeline (count and scatter passes)
   logic                 p1_v_ff;
   logic                 p2_v_ff;
   logic [PIDX_W-1:0]    p2_addr_ff;
   logic [CIDX_W-1:0]    s2_col_ff;
   logic [VAL_W-1:0]     s2_val_ff;
   logic                 fwd_v_ff;
   logic [PIDX_W-1:0]    fwd_addr_ff;
   logic [ECNT_W-1:0]    fwd_data_ff;

   // Prefix pass
   logic                 pre_v_ff;
   logic [PIDX_W-1:0]    pre_addr_ff;
   logic [ECNT_W-1:0]    sum_ff;

   // Response registers
   logic                 rsp_valid_ff;
   status_type           rsp_status_ff;
   logic [CNT_W-1:0]     rsp_count_ff;
   rsp_kind_type         rsp_kind_ff;

   // RAM ports
   logic                 crd_we;
   logic [EIDX_W-1:0]    crd_waddr;
   logic [CRD_W-1:0]     crd_wdata;
   logic [EIDX_W-1:0]    crd_raddr;
   logic [CRD_W-1:0]     crd_rdata;
   logic                 ptr_we;
   logic [PIDX_W-1:0]    ptr_waddr;
   logic [ECNT_W-1:0]    ptr_wdata;
   logic [PIDX_W-1:0]    ptr_raddr;
   logic [ECNT_W-1:0]    ptr_rdata;
   logic                 ns_we;
   logic [RIDX_W-1:0]    ns_waddr;
   logic [ECNT_W-1:0]    ns_wdata;
   logic [RIDX_W-1:0]    ns_raddr;
   logic [ECNT_W-1:0]    ns_rdata;
   logic                 pk_we;
   logic [EIDX_W-1:0]    pk_waddr;
   logic [PK_W-1:0]      pk_wdata;
   logic [EIDX_W-1:0]    pk_raddr;
   logic [PK_W-1:0]      pk_rdata;

   // Decoded command and pass control
   logic                 accept;
   logic                 load_oob;
   logic                 store_full;
   logic                 load_ok;
   logic                 count_bad;
   logic                 ptr_bad;
   logic                 slot_bad;
   logic                 issue;
   logic                 prefix_issue;
   logic                 entry_oob;
   logic [RIDX_W-1:0]    crd_row;
   logic [CIDX_W-1:0]    crd_col;
   logic [VAL_W-1:0]     crd_val;
   logic [ECNT_W-1:0]    rmw_rdata;
   logic [ECNT_W-1:0]    rmw_cur;
   logic [ECNT_W-1:0]    rmw_inc;
   logic [ECNT_W-1:0]    prefix_new;
   logic [PIDX_W-1:0]    rows_sat;
   logic [CCNT_W-1:0]    cols_sat;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;

   // Coordinate store read fields
   assign crd_row = crd_rdata[CRD_W-1 -: RIDX_W];
   assign crd_col = crd_rdata[VAL_W +: CIDX_W];
   assign crd_val = crd_rdata[VAL_W-1:0];

   // Command checks
   assign load_oob = (req_data.row_number == '0)
                  || (32'(req_data.row_number) > 32'(rows_ff))
                  || (req_data.col_number == '0)
                  || (32'(req_data.col_number) > 32'(cols_ff));
   assign store_full = (32'(total_ff) >= MAX_ENTRIES);
   assign load_ok    = accept && (req_data.mode == MODE_LOAD) && !load_oob && !store_full;
   assign count_bad  = (32'(total_ff) != 32'(decl_ff));
   assign ptr_bad    = !built_ff || (32'(req_data.read_position) > 32'(rows_ff));
   assign slot_bad   = !built_ff || (32'(req_data.read_position) >= 32'(total_ff));

   // Pass control
   assign issue        = (idx_ff < IW'(total_ff));
   assign prefix_issue = (idx_ff <= IW'(rows_ff));
   assign entry_oob    = (32'(crd_row) >= 32'(rows_ff)) || (32'(crd_col) >= 32'(cols_ff));

   // Read-modify-write with forwarding of the write made in the previous cycle
   assign rmw_rdata  = (state_ff == S_COUNT) ? ptr_rdata : ns_rdata;
   assign rmw_cur    = (fwd_v_ff && (fwd_addr_ff == p2_addr_ff)) ? fwd_data_ff : rmw_rdata;
   assign rmw_inc    = rmw_cur + ECNT_W'(1);
   assign prefix_new = sum_ff + ptr_rdata;

   // Saturate a dimension register write to 1..MAX
   always_comb begin
      if (csr_wdata[DIM_W-1:0] == '0) begin
         rows_sat = PIDX_W'(1);
         cols_sat = CCNT_W'(1);
      end else begin
         if (32'(csr_wdata[DIM_W-1:0]) > MAX_ROWS) rows_sat = PIDX_W'(MAX_ROWS);
         else rows_sat = PIDX_W'(csr_wdata[DIM_W-1:0]);
         if (32'(csr_wdata[DIM_W-1:0]) > MAX_COLS) cols_sat = CCNT_W'(MAX_COLS);
         else cols_sat = CCNT_W'(csr_wdata[DIM_W-1:0]);
      end
   end

   // RAM port steering
   always_comb begin
      crd_we    = load_ok;
      crd_waddr = EIDX_W'(total_ff);
      crd_wdata = {RIDX_W'(req_data.row_number - DIM_W'(1)),
                   CIDX_W'(req_data.col_number - DIM_W'(1)),
                   req_data.value_bits};
      crd_raddr = EIDX_W'(idx_ff);

      ptr_we    = 1'b0;
      ptr_waddr = PIDX_W'(idx_ff);
      ptr_wdata = '0;
      ptr_raddr = PIDX_W'(req_data.read_position);

      ns_we     = 1'b0;
      ns_waddr  = RIDX_W'(pre_addr_ff);
      ns_wdata  = prefix_new;
      ns_raddr  = crd_row;

      pk_we     = 1'b0;
      pk_waddr  = EIDX_W'(rmw_cur);
      pk_wdata  = {s2_col_ff, s2_val_ff};
      pk_raddr  = EIDX_W'(req_data.read_position);

      case (state_ff)
         S_CLEAR: begin
            ptr_we = 1'b1;
         end
         S_COUNT: begin
            ptr_raddr = PIDX_W'(crd_row) + PIDX_W'(1);
            ptr_we    = p2_v_ff;
            ptr_waddr = p2_addr_ff;
            ptr_wdata = rmw_inc;
         end
         S_PREFIX: begin
            ptr_raddr = PIDX_W'(idx_ff);
            ptr_we    = pre_v_ff;
            ptr_waddr = pre_addr_ff;
            ptr_wdata = prefix_new;
            ns_we     = pre_v_ff && (pre_addr_ff < rows_ff);
         end
         S_SCATTER: begin
            ns_we    = p2_v_ff;
            ns_waddr = RIDX_W'(p2_addr_ff);
            ns_wdata = rmw_inc;
            pk_we    = p2_v_ff;
         end
         default: begin
         end
      endcase
   end

   // Sequencer, configuration and response registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= '0;
         rows_ff      <= PIDX_W'(1);
         cols_ff      <= CCNT_W'(1);
         decl_ff      <= '0;
         total_ff     <= '0;
         built_ff     <= 1'b0;
         p1_v_ff      <= 1'b0;
         p2_v_ff      <= 1'b0;
         fwd_v_ff     <= 1'b0;
         pre_v_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rsp_kind_ff  <= RK_NONE;
      end else begin
         rsp_valid_ff <= 1'b0;

         // CSR writes; any write to a defined register makes the compressed form stale
         if (csr_we) begin
            case (csr_index)
               REG_NUM_ROWS: begin
                  rows_ff  <= rows_sat;
                  built_ff <= 1'b0;
               end
               REG_NUM_COLS: begin
                  cols_ff  <= cols_sat;
                  built_ff <= 1'b0;
               end
               REG_DECLARED_COUNT: begin
                  decl_ff  <= csr_wdata;
                  built_ff <= 1'b0;
               end
               default: begin
               end
            endcase
         end

         case (state_ff)
            S_IDLE: begin
               idx_ff   <= '0;
               p1_v_ff  <= 1'b0;
               p2_v_ff  <= 1'b0;
               fwd_v_ff <= 1'b0;
               pre_v_ff <= 1'b0;
               if (accept) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_kind_ff   <= RK_NONE;
                  rsp_status_ff <= ST_OK;
                  rsp_count_ff  <= CNT_W'(total_ff);
                  case (req_data.mode)
                     MODE_LOAD: begin
                        if (load_oob) begin
                           rsp_status_ff <= ST_BOUNDS;
                        end else if (store_full) begin
                           rsp_status_ff <= ST_FULL;
                        end else begin
                           total_ff     <= total_ff + ECNT_W'(1);
                           built_ff     <= 1'b0;
                           rsp_count_ff <= CNT_W'(total_ff + ECNT_W'(1));
                        end
                     end
                     MODE_BUILD: begin
                        built_ff <= 1'b0;
                        if (count_bad) begin
                           rsp_status_ff <= ST_COUNT;
                        end else begin
                           rsp_valid_ff <= 1'b0;
                           state_ff     <= S_SCAN;
                        end
                     end
                     MODE_READ_PTR: begin
                        if (ptr_bad) rsp_status_ff <= ST_BADREAD;
                        else rsp_kind_ff <= RK_PTR;
                     end
                     MODE_READ_SLOT: begin
                        if (slot_bad) rsp_status_ff <= ST_BADREAD;
                        else rsp_kind_ff <= RK_SLOT;
                     end
                     default: begin
                     end
                  endcase
               end
            end

            // Check every stored entry against the current bounds
            S_SCAN: begin
               if (issue) idx_ff <= idx_ff + IW'(1);
               p1_v_ff <= issue;
               if (p1_v_ff && entry_oob) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_kind_ff   <= RK_NONE;
                  rsp_status_ff <= ST_BOUNDS;
                  rsp_count_ff  <= CNT_W'(total_ff);
                  state_ff      <= S_IDLE;
               end else if (!issue && !p1_v_ff) begin
                  idx_ff   <= '0;
                  state_ff <= S_CLEAR;
               end
            end

            // Zero pointers 0..rows
            S_CLEAR: begin
               if (idx_ff == IW'(rows_ff)) begin
                  idx_ff   <= '0;
                  state_ff <= S_COUNT;
               end else begin
                  idx_ff <= idx_ff + IW'(1);
               end
            end

            // Per-row counts and stable scatter share one RMW pipeline
            S_COUNT, S_SCATTER: begin
               if (issue) idx_ff <= idx_ff + IW'(1);
               p1_v_ff <= issue;
               p2_v_ff <= p1_v_ff;
               if (state_ff == S_COUNT) p2_addr_ff <= PIDX_W'(crd_row) + PIDX_W'(1);
               else p2_addr_ff <= PIDX_W'(crd_row);
               s2_col_ff   <= crd_col;
               s2_val_ff   <= crd_val;
               fwd_v_ff    <= p2_v_ff;
               fwd_addr_ff <= p2_addr_ff;
               fwd_data_ff <= rmw_inc;
               if (!issue && !p1_v_ff && !p2_v_ff) begin
                  idx_ff <= '0;
                  if (state_ff == S_COUNT) begin
                     sum_ff   <= '0;
                     state_ff <= S_PREFIX;
                  end else begin
                     built_ff      <= 1'b1;
                     rsp_valid_ff  <= 1'b1;
                     rsp_kind_ff   <= RK_NONE;
                     rsp_status_ff <= ST_OK;
                     rsp_count_ff  <= CNT_W'(total_ff);
                     state_ff      <= S_IDLE;
                  end
               end
            end

            // Running sum turns counts into row pointers and next-slot seeds
            S_PREFIX: begin
               pre_v_ff    <= prefix_issue;
               pre_addr_ff <= PIDX_W'(idx_ff);
               if (prefix_issue) idx_ff <= idx_ff + IW'(1);
               if (pre_v_ff) sum_ff <= prefix_new;
               if (!prefix_issue && !pre_v_ff) begin
                  idx_ff   <= '0;
                  state_ff <= S_SCATTER;
               end
            end

            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // Result transfer: read data comes straight from the RAM output registers
   assign rsp_valid              = rsp_valid_ff;
   assign rsp_data.status        = rsp_status_ff;
   assign rsp_data.stored_count  = rsp_count_ff;
   assign rsp_data.row_start     = (rsp_kind_ff == RK_PTR) ? CNT_W'(ptr_rdata) : '0;
   assign rsp_data.col_out       = (rsp_kind_ff == RK_SLOT) ? COL_W'(pk_rdata[VAL_W +: CIDX_W])
                                                            : '0;
   assign rsp_data.value_out     = (rsp_kind_ff == RK_SLOT) ? pk_rdata[VAL_W-1:0] : '0;

   // Coordinate store: 0-based row, 0-based column and value in arrival order
   coo2csr_ram #(.WIDTH(CRD_W), .DEPTH(MAX_ENTRIES)) u_coord_ram (
      .clock (clock),
      .we    (crd_we),
      .waddr (crd_waddr),
      .wdata (crd_wdata),
      .raddr (crd_raddr),
      .rdata (crd_rdata)
   );

   // Row pointers, also the per-row count buffer during the build
   coo2csr_ram #(.WIDTH(ECNT_W), .DEPTH(MAX_ROWS + 1)) u_ptr_ram (
      .clock (clock),
      .we    (ptr_we),
      .waddr (ptr_waddr),
      .wdata (ptr_wdata),
      .raddr (ptr_raddr),
      .rdata (ptr_rdata)
   );

   // Next free compressed slot for each row
   coo2csr_ram #(.WIDTH(ECNT_W), .DEPTH(MAX_ROWS)) u_next_ram (
      .clock (clock),
      .we    (ns_we),
      .waddr (ns_waddr),
      .wdata (ns_wdata),
      .raddr (ns_raddr),
      .rdata (ns_rdata)
   );

   // Compressed-row column and value slots
   coo2csr_ram #(.WIDTH(PK_W), .DEPTH(MAX_ENTRIES)) u_packed_ram (
      .clock (clock),
      .we    (pk_we),
      .waddr (pk_waddr),
      .wdata (pk_wdata),
      .raddr (pk_raddr),
      .rdata (pk_rdata)
   );

endmodule
